>>> hdl/ucm_pkg.sv
// Package for the UPGMA cluster merger.
// Holds the fixed field widths used by the interfaces and the top level, and the sequence count reset value.
package ucm_pkg;
   localparam int IDX_W = 6;
   localparam int SIM_W = 16;
   localparam logic [IDX_W-1:0] SEQ_COUNT_RESET = 6'd32;
endpackage

>>> hdl/ucm_if.sv
// Channel interfaces of the UPGMA cluster merger: request, response and CSR write.
// Depends on ucm_pkg for field widths.
interface ucm_req_if import ucm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] row;
   logic [IDX_W-1:0] col;
   logic [SIM_W-1:0] similarity;
   logic             last;
   modport source (output valid, row, col, similarity, last, input ready);
   modport sink (input valid, row, col, similarity, last, output ready);
endinterface

interface ucm_rsp_if import ucm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SIM_W-1:0] score;
   logic [IDX_W-1:0] low_index;
   logic [IDX_W-1:0] high_index;
   logic [IDX_W-1:0] low_size;
   logic [IDX_W-1:0] high_size;
   logic [IDX_W-1:0] merged_size;
   logic             error;
   logic             last_res;
   modport source (output valid, score, low_index, high_index, low_size, high_size,
                   merged_size, error, last_res, input ready);
   modport sink (input valid, score, low_index, high_index, low_size, high_size,
                 merged_size, error, last_res, output ready);
endinterface

interface ucm_csr_if import ucm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> hdl/ucm_divider.sv
// Restoring divider, one quotient bit per cycle, for the cluster averages.
// Depends on ucm_pkg for the similarity width.
module ucm_divider import ucm_pkg::*; #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [SIM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (DEN_W+2)'(divisor)) begin
            rem_in = (DEN_W+1)'(trial - (DEN_W+2)'(divisor));
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = (DEN_W+1)'(trial);
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - CNT_W'(1);
         if (step_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[SIM_W-1:0];
endmodule

>>> hdl/upgma_cluster_merger_unit.sv
// UPGMA average-linkage cluster merger: top level with matrix memories and sequencer.
// Depends on ucm_pkg, the ucm interfaces and ucm_divider.
// Loading takes one request per cycle while the sequencer is idle. After the last entry, each
// round scans all n*n pairs, then for each active cluster other than the merged one sums its
// member pairs with the merged cluster, divides by their count and writes both mirrored entries.
// Reset is synchronous and clears control state; the matrix memories are not cleared.
module upgma_cluster_merger_unit import ucm_pkg::*; #(
   parameter int MAX_SEQS = 32
) (
   input  logic  clock,
   input  logic  reset,
   ucm_req_if.sink   req,
   ucm_rsp_if.source rsp,
   ucm_csr_if.sink   csr
);
   localparam int IW    = $clog2(MAX_SEQS);
   localparam int DEPTH = MAX_SEQS * MAX_SEQS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ACC_W = SIM_W + 2 * IW;
   localparam int DEN_W = 2 * IW + 1;
   localparam int SZ_W  = $clog2(MAX_SEQS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_DECIDE, ST_EMIT,
      ST_AVG_RD, ST_AVG_ADD, ST_DIV, ST_WR_A, ST_WR_B
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] seq_count_ff;
   logic [IW-1:0]    n_m1_ff, i_ff, j_ff, x_ff, y_ff, lo_ff, hi_ff, mc_ff;
   logic [IW-1:0]    rep_ff [MAX_SEQS];
   logic [MAX_SEQS-1:0] merged_ff;
   logic [SIM_W-1:0] best_ff, avg_ff;
   logic [IW-1:0]    a_ff, b_ff;
   logic             found_ff, qual_ff, sel_work_ff, div_start_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [DEN_W-1:0] cnt_ff;

   logic             rsp_valid_ff, err_ff, last_res_ff;
   logic [SIM_W-1:0] score_ff;
   logic [IDX_W-1:0] low_index_ff, high_index_ff, low_size_ff, high_size_ff, merged_size_ff;

   logic [SIM_W-1:0] orig_mem [DEPTH];
   logic [SIM_W-1:0] work_mem [DEPTH];
   logic [SIM_W-1:0] orig_q, work_q, cand;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             work_we;

   logic [MAX_SEQS-1:0] act, memb_i, memb_lo, memb_hi;
   logic [SZ_W-1:0]     ls, hs;
   logic [IDX_W-1:0]    row_m1, col_m1;
   logic                in_range, req_acc;
   logic [IDX_W:0]      n_full;
   logic                div_done;
   logic [SIM_W-1:0]    div_q;

   assign req_acc  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !reset;
   assign csr.ready = !reset;
   assign row_m1   = req.row - IDX_W'(1);
   assign col_m1   = req.col - IDX_W'(1);
   assign in_range = (req.row != '0) && (req.col != '0) &&
                     ((IDX_W+1)'(req.row) <= (IDX_W+1)'(MAX_SEQS)) &&
                     ((IDX_W+1)'(req.col) <= (IDX_W+1)'(MAX_SEQS));

   always_comb begin
      if (seq_count_ff < IDX_W'(2)) begin
         n_full = (IDX_W+1)'(2);
      end else if ((IDX_W+1)'(seq_count_ff) > (IDX_W+1)'(MAX_SEQS)) begin
         n_full = (IDX_W+1)'(MAX_SEQS);
      end else begin
         n_full = (IDX_W+1)'(seq_count_ff);
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_SEQS; k++) begin
         act[k]     = (rep_ff[k] == IW'(k));
         memb_i[k]  = (rep_ff[k] == i_ff);
         memb_lo[k] = (rep_ff[k] == lo_ff);
         memb_hi[k] = (rep_ff[k] == hi_ff);
      end
      ls = SZ_W'($countones(memb_lo));
      hs = SZ_W'($countones(memb_hi));
   end

   always_comb begin
      if (state_ff == ST_AVG_RD) begin
         rd_addr = AW'(x_ff * MAX_SEQS + y_ff);
      end else begin
         rd_addr = AW'(i_ff * MAX_SEQS + j_ff);
      end
      work_we = (state_ff == ST_WR_A) || (state_ff == ST_WR_B);
      if (state_ff == ST_WR_A) begin
         wr_addr = AW'(i_ff * MAX_SEQS + lo_ff);
      end else begin
         wr_addr = AW'(lo_ff * MAX_SEQS + i_ff);
      end
      cand = sel_work_ff ? work_q : orig_q;
   end

   always_ff @(posedge clock) begin
      if (req_acc && in_range) begin
         orig_mem[AW'(row_m1[IW-1:0] * MAX_SEQS + col_m1[IW-1:0])] <= req.similarity;
      end
      orig_q <= orig_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[wr_addr] <= avg_ff;
      end
      work_q <= work_mem[rd_addr];
   end

   ucm_divider #(.NUM_W(ACC_W), .DEN_W(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (acc_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_count_ff <= SEQ_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         merged_ff    <= '0;
         mc_ff        <= '0;
         div_start_ff <= 1'b0;
         for (int k = 0; k < MAX_SEQS; k++) begin
            rep_ff[k] <= IW'(k);
         end
      end else begin
         div_start_ff <= 1'b0;
         if (csr.valid) begin
            seq_count_ff <= csr.data;
         end
         if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req.last) begin
                  n_m1_ff   <= IW'(n_full - (IDX_W+1)'(1));
                  merged_ff <= '0;
                  mc_ff     <= '0;
                  for (int k = 0; k < MAX_SEQS; k++) begin
                     rep_ff[k] <= IW'(k);
                  end
                  i_ff      <= '0;
                  j_ff      <= '0;
                  best_ff   <= '0;
                  found_ff  <= 1'b0;
                  state_ff  <= ST_SCAN_RD;
               end
            end
            ST_SCAN_RD: begin
               qual_ff     <= act[i_ff] && act[j_ff] && (i_ff != j_ff);
               sel_work_ff <= merged_ff[i_ff] || merged_ff[j_ff];
               state_ff    <= ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               if (qual_ff && (cand > best_ff)) begin
                  best_ff  <= cand;
                  a_ff     <= i_ff;
                  b_ff     <= j_ff;
                  found_ff <= 1'b1;
               end
               if (j_ff == n_m1_ff) begin
                  j_ff <= '0;
                  if (i_ff == n_m1_ff) begin
                     state_ff <= ST_DECIDE;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= ST_SCAN_RD;
                  end
               end else begin
                  j_ff     <= j_ff + IW'(1);
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_DECIDE: begin
               lo_ff    <= (a_ff < b_ff) ? a_ff : b_ff;
               hi_ff    <= (a_ff < b_ff) ? b_ff : a_ff;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  if (!found_ff) begin
                     score_ff       <= '0;
                     low_index_ff   <= '0;
                     high_index_ff  <= '0;
                     low_size_ff    <= '0;
                     high_size_ff   <= '0;
                     merged_size_ff <= '0;
                     last_res_ff    <= 1'b1;
                     state_ff       <= ST_IDLE;
                  end else begin
                     score_ff       <= best_ff;
                     low_index_ff   <= IDX_W'((IDX_W+1)'(lo_ff) + (IDX_W+1)'(1));
                     high_index_ff  <= IDX_W'((IDX_W+1)'(hi_ff) + (IDX_W+1)'(1));
                     low_size_ff    <= IDX_W'(ls);
                     high_size_ff   <= IDX_W'(hs);
                     merged_size_ff <= IDX_W'((SZ_W+1)'(ls) + (SZ_W+1)'(hs));
                     last_res_ff    <= (mc_ff + IW'(1) == n_m1_ff);
                     for (int k = 0; k < MAX_SEQS; k++) begin
                        if (memb_lo[k] || memb_hi[k]) begin
                           rep_ff[k] <= lo_ff;
                        end
                     end
                     merged_ff[lo_ff] <= 1'b1;
                     mc_ff            <= mc_ff + IW'(1);
                     i_ff             <= '0;
                     x_ff             <= '0;
                     y_ff             <= '0;
                     acc_ff           <= '0;
                     cnt_ff           <= '0;
                     if (mc_ff + IW'(1) == n_m1_ff) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        state_ff <= ST_AVG_RD;
                     end
                  end
                  err_ff <= !found_ff;
               end
            end
            ST_AVG_RD: begin
               if (!act[i_ff] || (i_ff == lo_ff)) begin
                  if (i_ff == n_m1_ff) begin
                     i_ff     <= '0;
                     j_ff     <= '0;
                     best_ff  <= '0;
                     found_ff <= 1'b0;
                     state_ff <= ST_SCAN_RD;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end else begin
                  qual_ff  <= memb_i[x_ff] && memb_lo[y_ff];
                  state_ff <= ST_AVG_ADD;
               end
            end
            ST_AVG_ADD: begin
               if (qual_ff) begin
                  acc_ff <= acc_ff + ACC_W'(orig_q);
                  cnt_ff <= cnt_ff + DEN_W'(1);
               end
               if (y_ff == n_m1_ff) begin
                  y_ff <= '0;
                  if (x_ff == n_m1_ff) begin
                     x_ff         <= '0;
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIV;
                  end else begin
                     x_ff     <= x_ff + IW'(1);
                     state_ff <= ST_AVG_RD;
                  end
               end else begin
                  y_ff     <= y_ff + IW'(1);
                  state_ff <= ST_AVG_RD;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  avg_ff   <= div_q;
                  state_ff <= ST_WR_A;
               end
            end
            ST_WR_A: begin
               state_ff <= ST_WR_B;
            end
            ST_WR_B: begin
               acc_ff <= '0;
               cnt_ff <= '0;
               if (i_ff == n_m1_ff) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  best_ff  <= '0;
                  found_ff <= 1'b0;
                  state_ff <= ST_SCAN_RD;
               end else begin
                  i_ff     <= i_ff + IW'(1);
                  state_ff <= ST_AVG_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.score       = score_ff;
   assign rsp.low_index   = low_index_ff;
   assign rsp.high_index  = high_index_ff;
   assign rsp.low_size    = low_size_ff;
   assign rsp.high_size   = high_size_ff;
   assign rsp.merged_size = merged_size_ff;
   assign rsp.error       = err_ff;
   assign rsp.last_res    = last_res_ff;

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !err_ff |-> low_index_ff < high_index_ff || high_index_ff == '0)
      else $error("merged pair indices out of order");
   a_size_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !err_ff |-> merged_size_ff == IDX_W'(low_size_ff + high_size_ff))
      else $error("merged size does not match member counts");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
endmodule

>>> dv/upgma_cluster_merger_unit_tb.sv
// Self-checking testbench for the UPGMA cluster merger top level.
// Depends on ucm_pkg, the ucm channel interfaces and upgma_cluster_merger_unit.
// A scoreboard class predicts every merge result and checks the response stream in order.
`timescale 1ns / 100ps

module upgma_cluster_merger_unit_tb;
   import ucm_pkg::*;

   localparam int MAX_SEQS = 32;
   localparam int FILL_N   = 10;

   typedef struct packed {
      logic [SIM_W-1:0] score;
      logic [IDX_W-1:0] low_index;
      logic [IDX_W-1:0] high_index;
      logic [IDX_W-1:0] low_size;
      logic [IDX_W-1:0] high_size;
      logic [IDX_W-1:0] merged_size;
      logic             error;
      logic             last_res;
   } merge_type;

   class cluster_scoreboard_type;
      bit [SIM_W-1:0] orig_sim[MAX_SEQS*MAX_SEQS];
      bit [SIM_W-1:0] work_sim[MAX_SEQS*MAX_SEQS];
      bit [IDX_W-1:0] label[MAX_SEQS];
      bit [IDX_W-1:0] count_reg = SEQ_COUNT_RESET;
      merge_type      merges_q[$];
      int             mismatches = 0;

      function int rep_of(int k);
         return (label[k] != 0) ? int'(label[k]) - 1 : k;
      endfunction

      function int size_of(int rep, int n);
         int c;
         c = 0;
         for (int k = 0; k < n; k++) if (rep_of(k) == rep) c++;
         return c;
      endfunction

      function void set_count(bit [IDX_W-1:0] v);
         count_reg = v;
      endfunction

      function void cluster_all();
         int n, done, best, a, b, lo, hi, ls, hs;
         bit found;
         longint unsigned acc, cnt;
         merge_type m;
         n = count_reg;
         if (n < 2) n = 2;
         if (n > MAX_SEQS) n = MAX_SEQS;
         for (int i = 0; i < MAX_SEQS; i++) begin
            label[i] = 0;
            if (i < n) orig_sim[i*MAX_SEQS+i] = 0;
         end
         work_sim = orig_sim;
         done = 0;
         while (done < n - 1) begin
            best = 0; a = 0; b = 0; found = 0;
            for (int i = 0; i < n; i++) begin
               if (rep_of(i) != i) continue;
               for (int j = 0; j < n; j++) begin
                  if (rep_of(j) != j) continue;
                  if (work_sim[i*MAX_SEQS+j] > best) begin
                     best = work_sim[i*MAX_SEQS+j];
                     a = i; b = j; found = 1;
                  end
               end
            end
            if (!found) begin
               m = '0;
               m.error = 1'b1;
               m.last_res = 1'b1;
               merges_q.push_back(m);
               return;
            end
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            ls = size_of(lo, n);
            hs = size_of(hi, n);
            for (int i = 0; i < n; i++) begin
               if (rep_of(i) == lo || rep_of(i) == hi) label[i] = IDX_W'(lo + 1);
            end
            done++;
            m.score = SIM_W'(best);
            m.low_index = IDX_W'(lo + 1);
            m.high_index = IDX_W'(hi + 1);
            m.low_size = IDX_W'(ls);
            m.high_size = IDX_W'(hs);
            m.merged_size = IDX_W'(ls + hs);
            m.error = 1'b0;
            m.last_res = (done == n - 1);
            merges_q.push_back(m);
            for (int i = 0; i < n; i++) begin
               if (rep_of(i) != i || i == lo) continue;
               acc = 0; cnt = 0;
               for (int x = 0; x < n; x++) begin
                  if (rep_of(x) != i) continue;
                  for (int y = 0; y < n; y++) begin
                     if (rep_of(y) != lo) continue;
                     acc += orig_sim[x*MAX_SEQS+y];
                     cnt++;
                  end
               end
               work_sim[i*MAX_SEQS+lo] = (cnt != 0) ? SIM_W'(acc / cnt) : '0;
               work_sim[lo*MAX_SEQS+i] = work_sim[i*MAX_SEQS+lo];
            end
         end
      endfunction

      function void note_request(bit [IDX_W-1:0] r, bit [IDX_W-1:0] c,
                                 bit [SIM_W-1:0] s, bit l);
         if (r >= 1 && r <= MAX_SEQS && c >= 1 && c <= MAX_SEQS)
            orig_sim[(r-1)*MAX_SEQS + (c-1)] = s;
         if (l) cluster_all();
      endfunction

      function void check_result(merge_type got);
         merge_type exp;
         if (merges_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         exp = merges_q.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, actual %p", exp, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle = 0;
   int   rsp_stall = 0;
   int   items_sent = 0;
   cluster_scoreboard_type sb;

   ucm_req_if req_ch();
   ucm_rsp_if rsp_ch();
   ucm_csr_if csr_ch();

   upgma_cluster_merger_unit #(.MAX_SEQS(MAX_SEQS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(100_000_000);
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.score, rsp_ch.low_index, rsp_ch.high_index,
                          rsp_ch.low_size, rsp_ch.high_size, rsp_ch.merged_size,
                          rsp_ch.error, rsp_ch.last_res});
   end

   task automatic send_req(bit [IDX_W-1:0] r, bit [IDX_W-1:0] c,
                           bit [SIM_W-1:0] s, bit l);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.row <= r;
      req_ch.col <= c;
      req_ch.similarity <= s;
      req_ch.last <= l;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(r, c, s, l);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.merges_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_count(bit [IDX_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.set_count(v);
      @(posedge clock);
   endtask

   function automatic bit [SIM_W-1:0] pick_sim(int mode);
      case (mode)
         0: return SIM_W'($urandom_range(65535));
         1: return SIM_W'($urandom_range(3));
         default: begin
            case ($urandom_range(2))
               0: return '0;
               1: return '1;
               default: return SIM_W'($urandom_range(65535));
            endcase
         end
      endcase
   endfunction

   task automatic fill_matrix(int n, int mode, bit mirror, bit with_last);
      bit [SIM_W-1:0] s;
      for (int r = 1; r <= n; r++) begin
         for (int c = 1; c <= n; c++) begin
            if (mirror && c < r) continue;
            s = pick_sim(mode);
            if (mirror && c != r) send_req(IDX_W'(c), IDX_W'(r), s, 1'b0);
            send_req(IDX_W'(r), IDX_W'(c), s, with_last && r == n && c == n);
         end
      end
   endtask

   initial begin
      int n, mode, phase, k;
      bit [IDX_W-1:0] r, c;
      sb = new();
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.row <= '0;
      req_ch.col <= '0;
      req_ch.similarity <= '0;
      req_ch.last <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the used corner of the matrix with zeros: no positive pair at all.
      write_count(IDX_W'(FILL_N));
      for (int i = 1; i <= FILL_N; i++)
         for (int j = 1; j <= FILL_N; j++)
            send_req(IDX_W'(i), IDX_W'(j), '0, i == FILL_N && j == FILL_N);
      drain();

      // One positive pair merges, then nothing is left.
      send_req(6'd1, 6'd2, 16'd300, 1'b1);
      drain();
      send_req(6'd10, 6'd9, 16'hFFFF, 1'b1);
      drain();

      write_count(6'd2);
      send_req(6'd1, 6'd1, 16'hFFFF, 1'b0);
      send_req(6'd2, 6'd1, 16'd1, 1'b1);
      drain();
      write_count(6'd0);
      send_req(6'd1, 6'd2, 16'hFFFF, 1'b1);
      drain();
      write_count(6'd1);
      send_req(6'd2, 6'd2, 16'd7, 1'b1);
      drain();

      // Ties and an asymmetric pair, then a last request at an ignored position.
      write_count(6'd3);
      send_req(6'd1, 6'd2, 16'd5, 1'b0);
      send_req(6'd2, 6'd1, 16'd5, 1'b0);
      send_req(6'd1, 6'd3, 16'd5, 1'b0);
      send_req(6'd3, 6'd1, 16'd5, 1'b0);
      send_req(6'd2, 6'd3, 16'd5, 1'b0);
      send_req(6'd3, 6'd2, 16'd9, 1'b0);
      send_req(6'd0, 6'd5, 16'd100, 1'b0);
      send_req(6'd40, 6'd63, 16'd100, 1'b1);
      drain();

      phase = 0;
      while (items_sent < 320) begin
         case (phase % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 49; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 49; end
            default: begin send_idle = 12; rsp_stall = 12; end
         endcase
         phase++;
         k = $urandom_range(99);
         n = (k < 80) ? $urandom_range(2, 6) : $urandom_range(7, FILL_N);
         write_count((n == 2 && $urandom_range(1)) ? 6'($urandom_range(1)) : 6'(n));
         mode = $urandom_range(2);
         if ($urandom_range(1)) begin
            fill_matrix(n, mode, 1'($urandom_range(1)), 1'b0);
         end else begin
            repeat ($urandom_range(1, 8))
               send_req(IDX_W'($urandom_range(1, n)), IDX_W'($urandom_range(1, n)),
                        pick_sim(mode), 1'b0);
         end
         repeat ($urandom_range(0, 2)) begin
            r = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
            c = IDX_W'($urandom_range(63));
            if ($urandom_range(1)) begin
               send_req(r, c, pick_sim(0), 1'b0);
            end else begin
               send_req(c, r, pick_sim(0), 1'b0);
            end
         end
         if ($urandom_range(3) == 0) begin
            send_req(6'($urandom_range(33, 63)), IDX_W'($urandom_range(63)), pick_sim(0),
                     1'b1);
         end else begin
            send_req(IDX_W'($urandom_range(1, n)), IDX_W'($urandom_range(1, n)),
                     pick_sim(mode), 1'b1);
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.merges_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
